>>> src/i2c_slave_register_memory_top_macros.svh
// assertion macros shared by the i2c slave register memory rtl
// no dependencies; included by the modules that carry assertions
`ifndef I2C_SLAVE_REGISTER_MEMORY_TOP_MACROS_SVH
`define I2C_SLAVE_REGISTER_MEMORY_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CSRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2CSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/i2csrm_pkg.sv
// types, constants and helpers of the i2c slave register memory
// no dependencies
`default_nettype none

package i2csrm_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [7:0] NAK_FILL = 8'hFF;

    typedef logic [AW-1:0] t_addr;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_RX_BYTE = 3'd1,
        MODE_TX_SENT = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_HOST_WR = 3'd4,
        MODE_HOST_RD = 3'd5
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    function automatic t_addr ptr_advance(input t_addr p);
        t_addr r;
        if (32'(p) == DEPTH - 1) begin
            r = '0;
        end else begin
            r = p + t_addr'(1);
        end
        return r;
    endfunction

    function automatic t_addr byte_to_addr(input logic [7:0] b);
        t_addr r;
        r = t_addr'(32'(b) % DEPTH);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/i2csrm_if.sv
// item and result channels of the i2c slave register memory
// no dependencies
`default_nettype none

interface i2csrm_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       nak;
    logic [3:0] index;

    modport source (output valid, mode, data_byte, nak, index, input ready);
    modport sink   (input valid, mode, data_byte, nak, index, output ready);
endinterface

interface i2csrm_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic [3:0] pointer;

    modport source (output valid, tx_byte, read_data, pointer, input ready);
    modport sink   (input valid, tx_byte, read_data, pointer, output ready);
endinterface

`default_nettype wire

>>> src/i2c_slave_register_memory_top.sv
// top level of the i2c slave register memory
// depends on i2csrm_pkg, i2csrm_if, i2csrm_ctrl and i2csrm_dp
`default_nettype none

// Upper half of an i2c slave with a 16-entry transmit store and a 16-entry
// receive store. Each transaction on i_item is one bus event (start, byte
// received, byte sent with ack or nak, stop) or one host access (write a
// transmit entry, read a receive entry); each produces exactly one result on
// o_result carrying the transmit holding byte, the host read data (zero unless
// a host read) and the memory pointer. After reset or a stop the first
// received byte is the device address and is dropped, the second sets the
// pointer and preloads the holding byte, later bytes fill the receive store
// with post-increment; an acked send loads the current transmit entry and
// advances the pointer, a nak loads 0xff. The pointer wraps at the depth.
// In a transaction the stores are read in the accept cycle through their
// registered read port, and the state update and result load happen in the
// execute state. The next transaction is taken only once the execute state
// has completed, so a new one is not accepted while one is in progress; a
// result still waiting holds the execute state until the output register
// frees. Both stores read as zero after reset with no clearing pass.

module i2c_slave_register_memory_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    i2csrm_item_if.sink          i_item,
    i2csrm_result_if.source      o_result
);

    i2csrm_pkg::t_cmd w_cmd;

    // fsm: owns the handshakes and the result valid flag
    i2csrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    // datapath: protocol flags, pointer, stores and result payload
    i2csrm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (i_item.mode),
        .i_data_byte (i_item.data_byte),
        .i_nak       (i_item.nak),
        .i_index     (i_item.index),
        .o_tx_byte   (o_result.tx_byte),
        .o_read_data (o_result.read_data),
        .o_pointer   (o_result.pointer)
    );

endmodule

`default_nettype wire

>>> src/i2csrm_ctrl.sv
// sequencing fsm: accepts a transaction, runs it, hands off the result
// depends on i2csrm_pkg and the macro header
`default_nettype none
`include "i2c_slave_register_memory_top_macros.svh"

module i2csrm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output i2csrm_pkg::t_cmd   o_cmd
);

    i2csrm_pkg::t_state r_state, n_state;
    logic               r_out_vld, n_out_vld;
    logic               w_accept;
    logic               w_slot_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_vld || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2csrm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i2csrm_pkg::ST_EXEC;
                end
            end
            i2csrm_pkg::ST_EXEC: begin
                if (w_slot_free) begin
                    n_state = i2csrm_pkg::ST_IDLE;
                end
            end
            default: n_state = i2csrm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            i2csrm_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            i2csrm_pkg::ST_EXEC: begin
                o_cmd.commit  = w_slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= i2csrm_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    `I2CSRM_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, w_accept, r_state == i2csrm_pkg::ST_EXEC, "accepted transaction did not start")
    `I2CSRM_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit, r_out_vld, "committed result not presented")
    `I2CSRM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.commit && r_out_vld, i_out_ready, "result overwritten before taken")

endmodule

`default_nettype wire

>>> src/i2csrm_dp.sv
// datapath: flags, pointer, holding byte, both stores and result register
// depends on i2csrm_pkg
`default_nettype none

module i2csrm_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  i2csrm_pkg::t_cmd   i_cmd,
    input  wire  [2:0]         i_mode,
    input  wire  [7:0]         i_data_byte,
    input  wire                i_nak,
    input  wire  [3:0]         i_index,
    output logic [7:0]         o_tx_byte,
    output logic [7:0]         o_read_data,
    output logic [3:0]         o_pointer
);

    localparam int D = i2csrm_pkg::DEPTH;

    // captured transaction
    i2csrm_pkg::t_mode r_mode;
    logic [7:0]        r_byte;
    logic              r_nak;
    logic [3:0]        r_idx;

    // protocol state
    logic               r_exp_dev, n_exp_dev;
    logic               r_exp_mem, n_exp_mem;
    i2csrm_pkg::t_addr  r_ptr, n_ptr;
    logic [7:0]         r_hold, n_hold;
    logic [7:0]         n_rd;

    // stores, reset to zero through per-entry valid bits
    logic [7:0] r_tx_mem [D];
    logic [7:0] r_rx_mem [D];
    logic [D-1:0] r_tx_vld;
    logic [D-1:0] r_rx_vld;
    logic [7:0] r_tx_rd, r_rx_rd;
    logic       r_tx_rd_ok, r_rx_rd_ok;
    logic [7:0] w_tx_q, w_rx_q;

    i2csrm_pkg::t_addr w_tx_raddr;
    i2csrm_pkg::t_addr w_idx_addr;
    logic              w_idx_ok;
    logic              w_tx_we, w_rx_we;
    i2csrm_pkg::t_addr w_tx_waddr;

    // memory address phase reads the transmit entry at the new pointer
    always_comb begin
        if (i2csrm_pkg::t_mode'(i_mode) == i2csrm_pkg::MODE_RX_BYTE
                && !r_exp_dev && r_exp_mem) begin
            w_tx_raddr = i2csrm_pkg::byte_to_addr(i_data_byte);
        end else begin
            w_tx_raddr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i2csrm_pkg::t_mode'(i_mode);
            r_byte     <= i_data_byte;
            r_nak      <= i_nak;
            r_idx      <= i_index;
            r_tx_rd    <= r_tx_mem[w_tx_raddr];
            r_tx_rd_ok <= r_tx_vld[w_tx_raddr];
            r_rx_rd    <= r_rx_mem[i2csrm_pkg::t_addr'(i_index)];
            r_rx_rd_ok <= r_rx_vld[i2csrm_pkg::t_addr'(i_index)];
        end
    end

    assign w_tx_q     = r_tx_rd_ok ? r_tx_rd : 8'h00;
    assign w_rx_q     = r_rx_rd_ok ? r_rx_rd : 8'h00;
    assign w_idx_addr = i2csrm_pkg::t_addr'(r_idx);
    assign w_idx_ok   = 32'(r_idx) < D;

    always_comb begin
        n_exp_dev  = r_exp_dev;
        n_exp_mem  = r_exp_mem;
        n_ptr      = r_ptr;
        n_hold     = r_hold;
        n_rd       = 8'h00;
        w_tx_we    = 1'b0;
        w_rx_we    = 1'b0;
        w_tx_waddr = w_idx_addr;
        case (r_mode)
            i2csrm_pkg::MODE_RX_BYTE: begin
                if (r_exp_dev) begin
                    n_exp_dev = 1'b0;
                end else if (r_exp_mem) begin
                    n_exp_mem = 1'b0;
                    n_ptr     = i2csrm_pkg::byte_to_addr(r_byte);
                    n_hold    = w_tx_q;
                end else begin
                    w_rx_we = 1'b1;
                    n_ptr   = i2csrm_pkg::ptr_advance(r_ptr);
                end
            end
            i2csrm_pkg::MODE_TX_SENT: begin
                if (r_nak) begin
                    n_hold = i2csrm_pkg::NAK_FILL;
                end else begin
                    n_hold = w_tx_q;
                    n_ptr  = i2csrm_pkg::ptr_advance(r_ptr);
                end
            end
            i2csrm_pkg::MODE_STOP: begin
                n_exp_dev = 1'b1;
                n_exp_mem = 1'b1;
            end
            i2csrm_pkg::MODE_HOST_WR: begin
                w_tx_we = w_idx_ok;
            end
            i2csrm_pkg::MODE_HOST_RD: begin
                n_rd = w_idx_ok ? w_rx_q : 8'h00;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_tx_we) begin
            r_tx_mem[w_tx_waddr] <= r_byte;
        end
        if (i_cmd.commit && w_rx_we) begin
            r_rx_mem[r_ptr] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_dev <= 1'b1;
            r_exp_mem <= 1'b1;
            r_ptr     <= '0;
            r_hold    <= 8'h00;
            r_tx_vld  <= '0;
            r_rx_vld  <= '0;
        end else if (i_cmd.commit) begin
            r_exp_dev <= n_exp_dev;
            r_exp_mem <= n_exp_mem;
            r_ptr     <= n_ptr;
            r_hold    <= n_hold;
            if (w_tx_we) begin
                r_tx_vld[w_tx_waddr] <= 1'b1;
            end
            if (w_rx_we) begin
                r_rx_vld[r_ptr] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_tx_byte   <= n_hold;
            o_read_data <= n_rd;
            o_pointer   <= 4'(n_ptr);
        end
    end

endmodule

`default_nettype wire
